// ===== sv/pose_template_matcher_defines.svh =====
// Assertion macros for the pose template matcher checker.
// Depends on nothing; the including module supplies clk_i and rst_ni.
`ifndef POSE_TEMPLATE_MATCHER_DEFINES_SVH
`define POSE_TEMPLATE_MATCHER_DEFINES_SVH

// Same-cycle implication, checked out of reset
`define PTM_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("pose template matcher: check failed");

// Next-cycle implication, checked out of reset
`define PTM_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("pose template matcher: check failed");

`endif

// ===== sv/ptm_pkg.sv =====
// Shared types and constants for the pose template matcher.
// Used by ptm_cell and pose_template_matcher; depends on nothing.
package ptm_pkg;

  // Input item kinds (carried in tuser)
  localparam logic [1:0] OP_SAMPLE = 2'd0;
  localparam logic [1:0] OP_TARGET = 2'd1;
  localparam logic [1:0] OP_START  = 2'd2;

  // Configuration register indexes
  localparam logic [1:0] REG_POSE_COUNT = 2'd0;
  localparam logic [1:0] REG_THRESHOLD  = 2'd1;
  localparam logic [1:0] REG_TOTAL      = 2'd2;

  localparam int unsigned SUM_W = 48;
  localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};

  // Joint sample travelling down the row of pose cells
  typedef struct packed {
    logic               valid;
    logic [4:0]         joint;
    logic signed [15:0] angle;
    logic signed [16:0] vel;
  } smp_tok_t;

  // Frame-end compare travelling down the row; the last match wins
  typedef struct packed {
    logic        valid;
    logic        found;
    logic [15:0] start;
  } cmp_tok_t;

  // Template load data broadcast to all cells
  typedef struct packed {
    logic [4:0]         joint;
    logic signed [15:0] angle;
    logic signed [15:0] vel;
    logic [15:0]        frame;
  } load_t;

endpackage

// ===== sv/ptm_cell.sv =====
// One pose cell: template memory, squared-error pipeline, 48-bit accumulator.
// Depends on ptm_pkg.
module ptm_cell import ptm_pkg::*; #(
  parameter int unsigned JOINTS = 32
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           act_i,
  input  logic [SUM_W-1:0] thr_i,
  input  load_t          ld_i,
  input  logic           tmpl_we_i,
  input  logic           frame_we_i,
  input  logic           clr_i,
  input  smp_tok_t       smp_i,
  output smp_tok_t       smp_o,
  input  cmp_tok_t       cmp_i,
  output cmp_tok_t       cmp_o
);

  localparam int unsigned JW = (JOINTS > 1) ? $clog2(JOINTS) : 1;

  logic [31:0]        tmpl_mem [JOINTS];
  logic [31:0]        tmpl_rd_q;
  smp_tok_t           smp_q;
  logic               b_vld_q;
  logic signed [16:0] da;
  logic signed [17:0] dv;
  logic signed [33:0] prod_a;
  logic signed [35:0] prod_v;
  logic [31:0]        sqa_q;
  logic [33:0]        sqv_q;
  logic               c_vld_q;
  logic [34:0]        esum_d, esum_q;
  logic [SUM_W:0]     sum_wide;
  logic [SUM_W-1:0]   acc_d, acc_q;
  logic [15:0]        frame_q;
  cmp_tok_t           cmp_d, cmp_q;

  // Template store: {velocity, angle} per joint
  always_ff @(posedge clk_i) begin
    if (tmpl_we_i) begin
      tmpl_mem[JW'(ld_i.joint)] <= {ld_i.vel, ld_i.angle};
    end
  end

  always_ff @(posedge clk_i) begin
    if (smp_i.valid) begin
      tmpl_rd_q <= tmpl_mem[JW'(smp_i.joint)];
    end
  end

  always_ff @(posedge clk_i) begin
    if (frame_we_i) begin
      frame_q <= ld_i.frame;
    end
  end

  // Errors and their squares
  always_comb begin
    da     = $signed({tmpl_rd_q[15], tmpl_rd_q[15:0]})
           - $signed({smp_q.angle[15], smp_q.angle});
    dv     = $signed({{2{tmpl_rd_q[31]}}, tmpl_rd_q[31:16]})
           - $signed({smp_q.vel[16], smp_q.vel});
    prod_a = da * da;
    prod_v = dv * dv;
  end

  // Error sum, then saturating accumulate
  assign esum_d   = {3'b000, sqa_q} + {1'b0, sqv_q};
  assign sum_wide = {1'b0, acc_q} + (SUM_W + 1)'(esum_q);
  assign acc_d    = sum_wide[SUM_W] ? SUM_MAX : sum_wide[SUM_W-1:0];

  // Compare token picks up this pose when it matches
  always_comb begin
    cmp_d = cmp_i;
    if (cmp_i.valid && act_i && (acc_q <= thr_i)) begin
      cmp_d.found = 1'b1;
      cmp_d.start = frame_q;
    end
  end

  always_ff @(posedge clk_i) begin
    sqa_q  <= prod_a[31:0];
    sqv_q  <= prod_v[33:0];
    esum_q <= esum_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      smp_q   <= '0;
      b_vld_q <= 1'b0;
      c_vld_q <= 1'b0;
      acc_q   <= '0;
      cmp_q   <= '0;
    end else begin
      smp_q   <= smp_i;
      b_vld_q <= smp_q.valid;
      c_vld_q <= b_vld_q;
      cmp_q   <= cmp_d;
      if (clr_i) begin
        acc_q <= '0;
      end else if (c_vld_q && act_i) begin
        acc_q <= acc_d;
      end
    end
  end

  assign smp_o = smp_q;
  assign cmp_o = cmp_q;

endmodule

// ===== sv/pose_template_matcher.sv =====
// Pose template matcher. Each joint sample is accepted, then the block
// fetches and replaces the joint's previous angle, then the sample passes
// down the row of pose cells, one cell a cycle, each cell adding the squared
// angle and velocity errors into its saturating sum over a three-stage
// pipeline; the block takes no new item until the sample has drained. A
// sample that ends a frame also waits for any previous result to be taken,
// then a compare item walks the row (highest matching pose wins) and the
// sums are cleared. Loads and unused kinds do not enter the row. No
// clearing pass after reset. Depends on ptm_pkg and ptm_cell.
module pose_template_matcher import ptm_pkg::*; #(
  parameter int unsigned MAX_POSES  = 16,
  parameter int unsigned MAX_JOINTS = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // stream in
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // pose_index[3:0], joint_index[8:4], angle_value[24:9],
  // velocity_value[40:25], frame_value[56:41], zero fill
  input  logic [63:0] s_axis_tdata,
  input  logic [1:0]  s_axis_tuser,  // op[1:0]
  input  logic        s_axis_tlast,  // last_joint
  // stream out
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,  // frame_start[15:0], frame_total[31:16]
  output logic        m_axis_tuser,  // match_found
  // configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready
);

  localparam int unsigned JW = (MAX_JOINTS > 1) ? $clog2(MAX_JOINTS) : 1;
  localparam int unsigned CW = $clog2(MAX_POSES + 3);
  localparam logic [CW-1:0] DRAIN_LEN = CW'(MAX_POSES + 2);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_PREV  = 3'd1;
  localparam logic [2:0] S_DRAIN = 3'd2;
  localparam logic [2:0] S_CMP   = 3'd3;
  localparam logic [2:0] S_WAIT  = 3'd4;

  logic [2:0]       state_d, state_q;
  logic [CW-1:0]    cnt_d, cnt_q;

  logic [4:0]       pose_count_q;
  logic [SUM_W-1:0] thr_q;
  logic [15:0]      total_q;
  logic             cfg_we;

  logic [1:0]       op_q;
  logic [3:0]       pose_q;
  logic             last_q;
  load_t            ld_q;
  logic             in_acc;

  logic [15:0]      prev_mem [MAX_JOINTS];
  logic [15:0]      prev_rd_q;
  logic             prev_hit_q;
  logic [MAX_JOINTS-1:0] prev_vld_q;
  logic signed [15:0]    prev_ang;
  logic             joint_ok;
  logic             smp_go;

  logic             m_valid_q, m_found_q;
  logic [15:0]      m_start_q, m_total_q;

  smp_tok_t         smp_chain [MAX_POSES+1];
  cmp_tok_t         cmp_chain [MAX_POSES+1];
  logic [MAX_POSES-1:0] act;
  logic             clr;
  logic             cmp_done;

  // Configuration port
  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pose_count_q <= '0;
      thr_q        <= '0;
      total_q      <= '0;
    end else if (cfg_we) begin
      case (paddr[4:3])
        REG_POSE_COUNT: pose_count_q <= pwdata[4:0];
        REG_THRESHOLD:  thr_q        <= pwdata[SUM_W-1:0];
        REG_TOTAL:      total_q      <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[4:3])
      REG_POSE_COUNT: prdata = {59'd0, pose_count_q};
      REG_THRESHOLD:  prdata = {16'd0, thr_q};
      REG_TOTAL:      prdata = {48'd0, total_q};
      default:        prdata = '0;
    endcase
  end

  // Input register and previous-angle fetch
  assign s_axis_tready = (state_q == S_IDLE);
  assign in_acc        = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      op_q       <= s_axis_tuser;
      pose_q     <= s_axis_tdata[3:0];
      ld_q.joint <= s_axis_tdata[8:4];
      ld_q.angle <= s_axis_tdata[24:9];
      ld_q.vel   <= s_axis_tdata[40:25];
      ld_q.frame <= s_axis_tdata[56:41];
      last_q     <= s_axis_tlast;
      prev_rd_q  <= prev_mem[JW'(s_axis_tdata[8:4])];
      prev_hit_q <= prev_vld_q[JW'(s_axis_tdata[8:4])];
    end
  end

  assign joint_ok = (32'(ld_q.joint) < MAX_JOINTS);
  assign smp_go   = (state_q == S_PREV) && (op_q == OP_SAMPLE) && joint_ok;
  assign prev_ang = prev_hit_q ? prev_rd_q : 16'sd0;

  always_ff @(posedge clk_i) begin
    if (smp_go) begin
      prev_mem[JW'(ld_q.joint)] <= ld_q.angle;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_vld_q <= '0;
    end else if (smp_go) begin
      prev_vld_q[JW'(ld_q.joint)] <= 1'b1;
    end
  end

  // Head of the row: sample and compare items
  always_comb begin
    smp_chain[0].valid = smp_go;
    smp_chain[0].joint = ld_q.joint;
    smp_chain[0].angle = ld_q.angle;
    smp_chain[0].vel   = $signed({ld_q.angle[15], ld_q.angle})
                       - $signed({prev_ang[15], prev_ang});
    cmp_chain[0].valid = (state_q == S_CMP) && !m_valid_q;
    cmp_chain[0].found = 1'b0;
    cmp_chain[0].start = '0;
  end

  // Row of pose cells
  for (genvar p = 0; p < MAX_POSES; p++) begin : g_cell
    logic tmpl_we, frame_we;

    assign act[p]   = (32'(pose_count_q) > p);
    assign tmpl_we  = (state_q == S_PREV) && (op_q == OP_TARGET) && joint_ok
                    && (32'(pose_q) == p);
    assign frame_we = (state_q == S_PREV) && (op_q == OP_START)
                    && (32'(pose_q) == p);

    ptm_cell #(
      .JOINTS (MAX_JOINTS)
    ) u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .act_i      (act[p]),
      .thr_i      (thr_q),
      .ld_i       (ld_q),
      .tmpl_we_i  (tmpl_we),
      .frame_we_i (frame_we),
      .clr_i      (clr),
      .smp_i      (smp_chain[p]),
      .smp_o      (smp_chain[p+1]),
      .cmp_i      (cmp_chain[p]),
      .cmp_o      (cmp_chain[p+1])
    );
  end

  assign cmp_done = (state_q == S_WAIT) && cmp_chain[MAX_POSES].valid;
  assign clr      = cmp_done;

  // Sequencer
  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_acc) state_d = S_PREV;
      end
      S_PREV: begin
        if (op_q == OP_SAMPLE) begin
          state_d = S_DRAIN;
          cnt_d   = DRAIN_LEN;
        end else begin
          state_d = S_IDLE;
        end
      end
      S_DRAIN: begin
        if (cnt_q == '0) begin
          state_d = last_q ? S_CMP : S_IDLE;
        end else begin
          cnt_d = cnt_q - 1'b1;
        end
      end
      S_CMP: begin
        if (!m_valid_q) state_d = S_WAIT;
      end
      S_WAIT: begin
        if (cmp_done) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (cmp_done) begin
      m_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      m_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmp_done) begin
      m_found_q <= cmp_chain[MAX_POSES].found;
      m_start_q <= cmp_chain[MAX_POSES].start;
      m_total_q <= cmp_chain[MAX_POSES].found ? total_q : 16'd0;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tuser  = m_found_q;
  assign m_axis_tdata  = {m_total_q, m_start_q};

endmodule

// ===== sv/ptm_checker.sv =====
// Port-level checks for the pose template matcher, bound to the top level.
// Depends on pose_template_matcher_defines.svh.
`include "pose_template_matcher_defines.svh"

module ptm_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [31:0] m_axis_tdata,
  input logic        m_axis_tuser
);

  // A stalled result holds
  `PTM_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready,
                   m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))

  // No match: start frame and total both zero
  `PTM_ASSERT_SAME(a_nomatch_zero, m_axis_tvalid && !m_axis_tuser,
                   m_axis_tdata == 32'd0)

  // Each accepted item makes the block busy in the next cycle
  `PTM_ASSERT_NEXT(a_busy_after_item, s_axis_tvalid && s_axis_tready, !s_axis_tready)

  // A result only appears at the end of frame processing, never from idle
  `PTM_ASSERT_SAME(a_result_from_busy, $rose(m_axis_tvalid), $past(!s_axis_tready))

endmodule

bind pose_template_matcher ptm_checker u_ptm_checker (.*);
